// ===== hw/rtl/efg_pkg.sv =====
// Shared types and constants of the event flag group unit.
package efg_pkg;

  localparam int FLAG_COUNT = 64;
  localparam int AGE_WIDTH  = 8;
  localparam int RW_WIDTH   = 8;
  localparam int CMP_WIDTH  = (AGE_WIDTH > RW_WIDTH) ? AGE_WIDTH : RW_WIDTH;
  localparam int PADDR_W    = 3;

  localparam logic [RW_WIDTH-1:0] RACE_WINDOW_RESET = RW_WIDTH'(20);
  localparam logic [AGE_WIDTH-1:0] AGE_MAX = {AGE_WIDTH{1'b1}};

  typedef enum logic [2:0] {
    OP_SET       = 3'd0,
    OP_CLEAR     = 3'd1,
    OP_POLL      = 3'd2,
    OP_OVERWRITE = 3'd3,
    OP_TICK      = 3'd4
  } op_e;

  localparam logic [3:0] WAIT_AND = 4'h1;
  localparam logic [3:0] WAIT_OR  = 4'h2;

  localparam logic [3:0] CLR_NONE   = 4'h0;
  localparam logic [3:0] CLR_ALL    = 4'h1;
  localparam logic [3:0] CLR_TESTED = 4'h2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BUSY    = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef enum logic {
    CTRL_IDLE,
    CTRL_EXEC
  } ctrl_state_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [63:0] pattern;
    logic [3:0]  test_mode;
    logic [3:0]  consume_mode;
  } efg_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] flags_seen;
    logic [63:0] reinjected;
  } efg_out_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } efg_cmd_t;

endpackage

// ===== hw/rtl/efg_ctrl.sv =====
// Controller state machine: sequences capture and execution of each beat.
module efg_ctrl
  import efg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output efg_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTRL_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      CTRL_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = CTRL_EXEC;
        end
      end
      CTRL_EXEC: begin
        // The result register must be free, or be emptied in this cycle.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.execute = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = CTRL_IDLE;
        end
      end
      default: begin
        state_d = CTRL_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_exec_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.execute |=> out_valid_q)
    else $error("execution did not present a result");

  a_capture_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == CTRL_EXEC)
    else $error("captured beat not followed by execution state");

  a_exec_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CTRL_EXEC && out_valid_q && !out_ready_i) |=> state_q == CTRL_EXEC)
    else $error("execution left while result register was full");

endmodule

// ===== hw/rtl/efg_datapath.sv =====
// Datapath: flag word, per-bit stamps and ages, operation logic, result register.
module efg_datapath
  import efg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  efg_cmd_t            cmd_i,
  input  efg_in_t             in_data_i,
  input  logic [RW_WIDTH-1:0] race_window_i,
  output efg_out_t            out_data_o
);

  efg_in_t                  in_q;
  efg_out_t                 out_q;
  logic [FLAG_COUNT-1:0]    word_q, word_d;
  logic [FLAG_COUNT-1:0]    valid_q, valid_d;
  logic [AGE_WIDTH-1:0]     age_q [FLAG_COUNT];
  logic [AGE_WIDTH-1:0]     age_d [FLAG_COUNT];
  efg_out_t                 res;

  logic [FLAG_COUNT-1:0] pat, missing, reinj, word_ri, hit, drop, restart;
  logic                  poll_ok, met, do_tick;

  assign pat     = in_q.pattern[FLAG_COUNT-1:0];
  assign poll_ok = (pat != '0) && (in_q.test_mode == WAIT_AND || in_q.test_mode == WAIT_OR)
                   && (in_q.consume_mode == CLR_NONE || in_q.consume_mode == CLR_ALL
                       || in_q.consume_mode == CLR_TESTED);
  assign missing = pat & ~word_q;

  // Race guard: a wanted bit that is gone but was stamped recently comes back.
  always_comb begin
    for (int i = 0; i < FLAG_COUNT; i++) begin
      reinj[i] = missing[i] && valid_q[i] && (age_q[i] != AGE_MAX)
                 && (CMP_WIDTH'(age_q[i]) < CMP_WIDTH'(race_window_i));
    end
  end

  assign word_ri = word_q | reinj;
  assign hit     = word_ri & pat;
  assign met     = (in_q.test_mode == WAIT_AND) ? (hit == pat) : (hit != '0);

  always_comb begin
    word_d     = word_q;
    drop       = '0;
    restart    = '0;
    do_tick    = 1'b0;
    res.status     = ST_OK;
    res.reinjected = '0;
    res.flags_seen = 64'(word_q);
    case (in_q.operation)
      OP_SET: begin
        word_d         = word_q | pat;
        restart        = pat;
        res.flags_seen = 64'(word_q | pat);
      end
      OP_CLEAR: begin
        word_d         = word_q & pat;
        res.flags_seen = 64'(word_q & pat);
      end
      OP_OVERWRITE: begin
        word_d         = pat;
        res.flags_seen = 64'(pat);
      end
      OP_TICK: begin
        do_tick = 1'b1;
      end
      OP_POLL: begin
        if (!poll_ok) begin
          res.status = ST_INVALID;
        end else begin
          word_d         = word_ri;
          drop           = reinj;
          res.flags_seen = 64'(word_ri);
          res.reinjected = 64'(reinj);
          if (!met) begin
            res.status = ST_BUSY;
          end else if (in_q.consume_mode == CLR_ALL) begin
            word_d = '0;
            drop   = '1;
          end else if (in_q.consume_mode == CLR_TESTED) begin
            word_d = word_ri & ~pat;
            drop   = reinj | pat;
          end
        end
      end
      default: begin
        res.status = ST_INVALID;
      end
    endcase
  end

  always_comb begin
    valid_d = (valid_q | restart) & ~drop;
    for (int i = 0; i < FLAG_COUNT; i++) begin
      age_d[i] = age_q[i];
      if (restart[i] || drop[i]) begin
        age_d[i] = '0;
      end else if (do_tick && valid_q[i] && age_q[i] != AGE_MAX) begin
        age_d[i] = age_q[i] + AGE_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q  <= '0;
      valid_q <= '0;
      for (int i = 0; i < FLAG_COUNT; i++) begin
        age_q[i] <= '0;
      end
    end else if (cmd_i.execute) begin
      word_q  <= word_d;
      valid_q <= valid_d;
      for (int i = 0; i < FLAG_COUNT; i++) begin
        age_q[i] <= age_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_data_i;
    end
    if (cmd_i.execute) begin
      out_q <= res;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== hw/rtl/event_flag_group_unit.sv =====
// Top level of the event flag group unit: APB register, controller and datapath.
// A beat is captured into the input register in the idle state and executed in
// the execute state, which writes the result register; a new beat is taken only
// after the last one has executed, and execution waits while that register is full.
// Reset clears the flag word, all stamps and ages, and sets race_window to 20.
// No clearing pass follows reset; the first beat is taken right away.
module event_flag_group_unit
  import efg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  efg_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output efg_out_t           out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  efg_cmd_t            cmd;
  logic [RW_WIDTH-1:0] race_window_q;
  logic                sel_rw;

  assign pready = 1'b1;
  assign sel_rw = (paddr[PADDR_W-1:2] == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      race_window_q <= RACE_WINDOW_RESET;
    end else if (psel && penable && pwrite && pready && sel_rw) begin
      race_window_q <= pwdata[RW_WIDTH-1:0];
    end
  end

  assign prdata = sel_rw ? 32'(race_window_q) : 32'd0;

  efg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  efg_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .in_data_i     (in_data_i),
    .race_window_i (race_window_q),
    .out_data_o    (out_data_o)
  );

endmodule

// ===== bench/tb_event_flag_group_unit.sv =====
// Self-checking testbench of the event flag group unit with a cycle-free flag predictor.
`timescale 1ns / 100ps

module tb_event_flag_group_unit;
  import efg_pkg::*;

  localparam logic [PADDR_W-1:0] RACE_WINDOW_ADDR = '0;
  localparam logic [63:0] WORD_MASK = 64'((65'd1 << FLAG_COUNT) - 65'd1);

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  efg_in_t            in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  efg_out_t           out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Predicted state of the flag group.
  logic [63:0]          model_flags;
  logic [63:0]          model_stamped;
  logic [AGE_WIDTH-1:0] model_age [FLAG_COUNT];
  logic [RW_WIDTH-1:0]  model_window;

  efg_out_t flag_reply_q [$];
  efg_out_t reply_want;
  int       fail_count = 0;

  // Sender and receiver idling controls.
  bit idle_enable = 1'b1;
  int burst_left = 0;
  int hold_request = 0;

  event_flag_group_unit uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb_event_flag_group_unit NOT OK");
    $finish;
  end

  function automatic void drop_stamps(input logic [63:0] bits);
    int i;
    for (i = 0; i < FLAG_COUNT; i++) begin
      if (bits[i]) begin
        model_stamped[i] = 1'b0;
        model_age[i] = '0;
      end
    end
  endfunction

  function automatic efg_out_t apply_flag_op(input efg_in_t beat);
    efg_out_t    res;
    logic [63:0] pat;
    logic [63:0] missing;
    logic [63:0] reinj;
    logic [63:0] hit;
    logic        met;
    int          i;
    pat = beat.pattern & WORD_MASK;
    res.status = ST_OK;
    res.reinjected = '0;
    res.flags_seen = model_flags;
    case (beat.operation)
      OP_SET: begin
        model_flags |= pat;
        for (i = 0; i < FLAG_COUNT; i++) begin
          if (pat[i]) begin
            model_stamped[i] = 1'b1;
            model_age[i] = '0;
          end
        end
        res.flags_seen = model_flags;
      end
      OP_CLEAR: begin
        model_flags &= pat;
        res.flags_seen = model_flags;
      end
      OP_OVERWRITE: begin
        model_flags = pat;
        res.flags_seen = model_flags;
      end
      OP_TICK: begin
        for (i = 0; i < FLAG_COUNT; i++) begin
          if (model_stamped[i] && model_age[i] != AGE_MAX) model_age[i] = model_age[i] + 1'b1;
        end
      end
      OP_POLL: begin
        if (pat == '0 || (beat.test_mode != WAIT_AND && beat.test_mode != WAIT_OR) ||
            beat.consume_mode > CLR_TESTED) begin
          res.status = ST_INVALID;
        end else begin
          // Bits that vanished shortly after being set come back before the test.
          missing = pat & ~model_flags;
          reinj = '0;
          for (i = 0; i < FLAG_COUNT; i++) begin
            if (missing[i] && model_stamped[i] &&
                CMP_WIDTH'(model_age[i]) < CMP_WIDTH'(model_window) &&
                model_age[i] != AGE_MAX) reinj[i] = 1'b1;
          end
          model_flags |= reinj;
          drop_stamps(reinj);
          hit = model_flags & pat;
          met = (beat.test_mode == WAIT_AND) ? (hit == pat) : (hit != '0);
          res.flags_seen = model_flags;
          res.reinjected = reinj;
          if (!met) begin
            res.status = ST_BUSY;
          end else if (beat.consume_mode == CLR_ALL) begin
            model_flags = '0;
            drop_stamps('1);
          end else if (beat.consume_mode == CLR_TESTED) begin
            model_flags &= ~pat;
            drop_stamps(pat);
          end
        end
      end
      default: res.status = ST_INVALID;
    endcase
    return res;
  endfunction

  function automatic efg_in_t beat_of(input logic [2:0] op, input logic [63:0] pat,
                                      input logic [3:0] wm, input logic [3:0] cm);
    efg_in_t b;
    b.operation = op;
    b.pattern = pat;
    b.test_mode = wm;
    b.consume_mode = cm;
    return b;
  endfunction

  task automatic send_beat(input efg_in_t beat);
    int gap;
    if (idle_enable && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (!in_ready);
    flag_reply_q.push_back(apply_flag_op(beat));
  endtask

  task automatic send_op(input logic [2:0] op, input logic [63:0] pat,
                         input logic [3:0] wm, input logic [3:0] cm);
    send_beat(beat_of(op, pat, wm, cm));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (flag_reply_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input logic write, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= RACE_WINDOW_ADDR;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (write) model_window = wdata[RW_WIDTH-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Only the low byte is meaningful; the upper write bits are random.
  task automatic program_race_window(input logic [RW_WIDTH-1:0] value);
    logic [31:0] rdata;
    logic [31:0] wdata;
    wdata = $urandom;
    wdata[RW_WIDTH-1:0] = value;
    apb_access(1'b1, wdata, rdata);
    apb_access(1'b0, '0, rdata);
    if (rdata !== 32'(model_window)) begin
      $error("race_window: expected %0d, got %0d", model_window, rdata);
      fail_count++;
    end
  endtask

  function automatic logic [63:0] pick_pattern();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1:    return r;
      2:       return 64'd1 << $urandom_range(0, FLAG_COUNT - 1);
      3:       return (64'd1 << $urandom_range(0, FLAG_COUNT - 1)) |
                      (64'd1 << $urandom_range(0, FLAG_COUNT - 1));
      4:       return WORD_MASK;
      5:       return '0;
      6, 7:    return model_stamped & (r | (r >> 7));
      default: return (model_flags | model_stamped) & r;
    endcase
  endfunction

  function automatic efg_in_t random_beat();
    efg_in_t b;
    int      w;
    b.pattern = pick_pattern();
    b.test_mode = 4'($urandom);
    b.consume_mode = 4'($urandom);
    w = $urandom_range(0, 99);
    if (w < 22) begin
      b.operation = OP_SET;
    end else if (w < 34) begin
      // Mostly masks that wipe only a few flags, so that the race guard has work.
      b.operation = OP_CLEAR;
      if ($urandom_range(0, 3) != 0) b.pattern = ~pick_pattern();
    end else if (w < 42) begin
      b.operation = OP_OVERWRITE;
    end else if (w < 60) begin
      b.operation = OP_TICK;
    end else if (w < 95) begin
      b.operation = OP_POLL;
      if ($urandom_range(0, 9) != 0) b.test_mode = $urandom_range(0, 1) ? WAIT_AND : WAIT_OR;
      if ($urandom_range(0, 9) != 0) b.consume_mode = 4'($urandom_range(0, 2));
    end else begin
      b.operation = 3'($urandom_range(5, 7));
    end
    return b;
  endfunction

  task automatic test_directed_ops();
    send_op(OP_POLL, WORD_MASK, WAIT_AND, CLR_NONE);
    send_op(OP_SET, WORD_MASK, 4'h0, 4'h0);
    send_op(OP_SET, 64'd0, 4'hF, 4'hF);
    send_op(OP_POLL, WORD_MASK, WAIT_AND, CLR_NONE);
    send_op(OP_CLEAR, 64'd0, 4'h0, 4'h0);
    send_op(OP_TICK, 64'd0, 4'h0, 4'h0);
    send_op(OP_POLL, 64'h8000_0000_0000_0001, WAIT_OR, CLR_TESTED);
    send_op(OP_POLL, WORD_MASK, WAIT_AND, CLR_ALL);
    send_op(OP_OVERWRITE, WORD_MASK, 4'h0, 4'h0);
    send_op(OP_POLL, WORD_MASK, WAIT_AND, CLR_ALL);
    send_op(OP_OVERWRITE, 64'h5555_5555_5555_5555, 4'h0, 4'h0);
    send_op(OP_POLL, 64'd0, WAIT_AND, CLR_NONE);
    send_op(OP_POLL, 64'h1, 4'h0, CLR_NONE);
    send_op(OP_POLL, 64'h1, 4'hF, CLR_NONE);
    send_op(OP_POLL, 64'h1, WAIT_OR, 4'h3);
    send_op(OP_POLL, 64'h1, WAIT_AND, 4'hF);
    send_op(3'd5, WORD_MASK, WAIT_AND, CLR_ALL);
    send_op(3'd6, 64'h1, WAIT_OR, CLR_NONE);
    send_op(3'd7, 64'd0, 4'hF, 4'hF);
    // A busy poll still brings back recently set flags.
    send_op(OP_SET, 64'hF0, 4'h0, 4'h0);
    send_op(OP_OVERWRITE, 64'd0, 4'h0, 4'h0);
    send_op(OP_POLL, 64'h1F0, WAIT_AND, CLR_NONE);
    send_op(OP_CLEAR, WORD_MASK, 4'h0, 4'h0);
    send_op(OP_POLL, 64'h100, WAIT_OR, CLR_NONE);
    send_op(OP_POLL, 64'hF0, WAIT_OR, CLR_NONE);
  endtask

  task automatic test_race_window_settings();
    wait_drained();
    program_race_window('0);
    send_op(OP_SET, 64'h3, 4'h0, 4'h0);
    send_op(OP_OVERWRITE, 64'd0, 4'h0, 4'h0);
    send_op(OP_POLL, 64'h3, WAIT_OR, CLR_NONE);
    wait_drained();
    program_race_window(RW_WIDTH'(1));
    send_op(OP_SET, 64'h3, 4'h0, 4'h0);
    send_op(OP_OVERWRITE, 64'd0, 4'h0, 4'h0);
    send_op(OP_POLL, 64'h1, WAIT_AND, CLR_NONE);
    send_op(OP_TICK, 64'd0, 4'h0, 4'h0);
    send_op(OP_CLEAR, 64'd0, 4'h0, 4'h0);
    send_op(OP_POLL, 64'h2, WAIT_AND, CLR_NONE);
    wait_drained();
    program_race_window(RACE_WINDOW_RESET);
  endtask

  // The oldest flag saturates and must stay down; the younger one still returns.
  task automatic test_age_saturation();
    wait_drained();
    program_race_window('1);
    send_op(OP_SET, 64'h1, 4'h0, 4'h0);
    send_op(OP_TICK, 64'd0, 4'h0, 4'h0);
    send_op(OP_SET, 64'h2, 4'h0, 4'h0);
    repeat (int'(AGE_MAX) - 1) send_op(OP_TICK, 64'd0, 4'h0, 4'h0);
    send_op(OP_OVERWRITE, 64'd0, 4'h0, 4'h0);
    send_op(OP_POLL, 64'h3, WAIT_AND, CLR_NONE);
  endtask

  task automatic test_output_backpressure();
    wait_drained();
    idle_enable = 1'b0;
    hold_request = 80;
    repeat (30) send_beat(random_beat());
    wait_drained();
    idle_enable = 1'b1;
  endtask

  task automatic test_random_traffic();
    int               phase;
    logic [RW_WIDTH-1:0] w;
    for (phase = 0; phase < 7; phase++) begin
      case (phase)
        0:       w = RACE_WINDOW_RESET;
        1:       w = '0;
        2:       w = '1;
        3:       w = RW_WIDTH'(1);
        default: w = RW_WIDTH'($urandom_range(2, 64));
      endcase
      wait_drained();
      program_race_window(w);
      repeat (105) send_beat(random_beat());
    end
  endtask

  initial begin : receiver
    int style;
    int span;
    int hold_left;
    style = 0;
    span = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        if (span == 0) begin
          style = $urandom_range(0, 4);
          span = $urandom_range(4, 40);
        end
        span--;
        case (style)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom);
          2:       out_ready <= ~out_ready;
          3:       out_ready <= ($urandom_range(0, 7) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (flag_reply_q.size() == 0) begin
        $error("result beat with no pending expectation");
        fail_count++;
      end else begin
        reply_want = flag_reply_q.pop_front();
        if (out_data.status !== reply_want.status) begin
          $error("status: expected %0d, got %0d", reply_want.status, out_data.status);
          fail_count++;
        end
        if (out_data.flags_seen !== reply_want.flags_seen) begin
          $error("flags_seen: expected %h, got %h", reply_want.flags_seen,
                 out_data.flags_seen);
          fail_count++;
        end
        if (out_data.reinjected !== reply_want.reinjected) begin
          $error("reinjected: expected %h, got %h", reply_want.reinjected,
                 out_data.reinjected);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int i;
    model_flags = '0;
    model_stamped = '0;
    for (i = 0; i < FLAG_COUNT; i++) model_age[i] = '0;
    model_window = RACE_WINDOW_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_ops();
    test_race_window_settings();
    test_age_saturation();
    test_output_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (10) @(posedge clk);
    if (flag_reply_q.size() != 0) begin
      $error("%0d expected results never arrived", flag_reply_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb_event_flag_group_unit OK");
    end else begin
      $display("tb_event_flag_group_unit NOT OK");
    end
    $finish;
  end

endmodule
